### rtl/core/rdc_pkg.sv
// shared constants, types and radix decode for the radix digit converter
package rdc_pkg;

	// default operand width
	localparam int VALUE_BITS_DEF = 31;

	// bits of the working quotient handled by the divide unit per cycle
	localparam int CHUNK_BITS = 8;

	localparam int DIGIT_W = 4;
	localparam int SEL_W   = 2;

	// radix_select codes
	localparam logic [SEL_W-1:0] SEL_BASE2  = 2'd0;
	localparam logic [SEL_W-1:0] SEL_BASE5  = 2'd1;
	localparam logic [SEL_W-1:0] SEL_BASE12 = 2'd2;

	// divisors
	localparam logic [DIGIT_W-1:0] RADIX_TWO    = 4'd2;
	localparam logic [DIGIT_W-1:0] RADIX_FIVE   = 4'd5;
	localparam logic [DIGIT_W-1:0] RADIX_TWELVE = 4'd12;

	// running remainder and quotient-nonzero flag of one digit's division
	typedef struct packed {
		logic [DIGIT_W-1:0] rem;
		logic               nz;
	} rdc_acc_t;

	// decode the selector, the unused code falls back to base 2
	function automatic logic [DIGIT_W-1:0] radix_divisor(input logic [SEL_W-1:0] sel);
		logic [DIGIT_W-1:0] d;
		case (sel)
			SEL_BASE5:  d = RADIX_FIVE;
			SEL_BASE12: d = RADIX_TWELVE;
			default:    d = RADIX_TWO;
		endcase
		return d;
	endfunction

endpackage

### rtl/core/rdc_div_unit.sv
// shared divide unit: one chunk of a constant-divisor long division, or a base-2 shift
module rdc_div_unit #(
	parameter int VALUE_BITS = rdc_pkg::VALUE_BITS_DEF,
	localparam int PAD_BITS =
		((VALUE_BITS + rdc_pkg::CHUNK_BITS - 1) / rdc_pkg::CHUNK_BITS) * rdc_pkg::CHUNK_BITS
) (
	input  logic [rdc_pkg::DIGIT_W-1:0] divisor,
	input  logic                        base2,
	input  logic [PAD_BITS-1:0]         w,
	input  rdc_pkg::rdc_acc_t           acc_in,
	output logic [PAD_BITS-1:0]         w_next,
	output rdc_pkg::rdc_acc_t           acc_out,
	output logic [rdc_pkg::DIGIT_W-1:0] digit
);
	import rdc_pkg::*;

	logic [CHUNK_BITS-1:0] top_chunk;
	logic [CHUNK_BITS-1:0] q_chunk;
	logic [DIGIT_W-1:0]    r_out;

	assign top_chunk = w[PAD_BITS-1 -: CHUNK_BITS];

	// restoring division of the top chunk, one quotient bit per step
	always_comb begin
		logic [DIGIT_W-1:0] r;
		logic [DIGIT_W:0]   r2;
		r = acc_in.rem;
		q_chunk = '0;
		for (int i = CHUNK_BITS - 1; i >= 0; i--) begin
			r2 = {r, top_chunk[i]};
			if (r2 >= {1'b0, divisor}) begin
				q_chunk[i] = 1'b1;
				r2 = r2 - {1'b0, divisor};
			end
			r = r2[DIGIT_W-1:0];
		end
		r_out = r;
	end

	// base 2 shifts one bit out, other bases rotate the quotient chunk in
	always_comb begin
		if (base2) begin
			w_next      = w >> 1;
			digit       = {{(DIGIT_W-1){1'b0}}, w[0]};
			acc_out.rem = '0;
			acc_out.nz  = |(w >> 1);
		end else begin
			w_next      = (w << CHUNK_BITS) | PAD_BITS'(q_chunk);
			digit       = r_out;
			acc_out.rem = r_out;
			acc_out.nz  = acc_in.nz | (|q_chunk);
		end
	end

endmodule

### rtl/core/rdc_digit_mem.sv
// digit store: one write port, one registered read port
module rdc_digit_mem #(
	parameter int VALUE_BITS = rdc_pkg::VALUE_BITS_DEF,
	localparam int IDX_W = $clog2(VALUE_BITS)
) (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [IDX_W-1:0]            wr_addr,
	input  logic [rdc_pkg::DIGIT_W-1:0] wr_data,
	input  logic                        rd_en,
	input  logic [IDX_W-1:0]            rd_addr,
	output logic [rdc_pkg::DIGIT_W-1:0] rd_data
);
	import rdc_pkg::*;

	logic [DIGIT_W-1:0] mem_q [VALUE_BITS];
	logic [DIGIT_W-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read, held while no read is issued
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### rtl/core/radix_digit_converter.sv
// top level: sequencer, radix register and output handshake of the radix digit converter
// Converts an unsigned value to base 2, 5 or 12 (radix_select 0, 1, 2; code 3 acts as base 2)
// and returns the digits most significant first, last set on the final digit; zero gives a
// single digit 0. One item is worked at a time and item_stall stays high until its last digit
// is taken. In base 2 each digit is one shift of the shared divide unit; in
// bases 5 and 12 the unit divides 8 bits of the quotient per cycle and works through
// every chunk of the padded quotient for each digit. After division the ST_LOAD state
// reads the digit store, then one digit leaves per cycle while result_stall is low.
// radix_select must only be written while the block is idle.
module radix_digit_converter #(
	parameter int VALUE_BITS = rdc_pkg::VALUE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [rdc_pkg::SEL_W-1:0]   cfg_wr_data,
	input  logic                        item_valid,
	output logic                        item_stall,
	input  logic [VALUE_BITS-1:0]       value,
	output logic                        result_valid,
	input  logic                        result_stall,
	output logic [rdc_pkg::DIGIT_W-1:0] digit,
	output logic                        last
);
	import rdc_pkg::*;

	localparam int NCHUNK   = (VALUE_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
	localparam int PAD_BITS = NCHUNK * CHUNK_BITS;
	localparam int IDX_W    = $clog2(VALUE_BITS);
	localparam int CW       = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(VALUE_BITS - 1);
	localparam logic [CW-1:0]    LAST_CHNK = CW'(NCHUNK - 1);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DIV  = 4'b0010,
		ST_LOAD = 4'b0100,
		ST_SHOW = 4'b1000
	} state_t;

	state_t             state_q;
	logic [SEL_W-1:0]   radix_select_q;
	logic [PAD_BITS-1:0] w_q;
	rdc_acc_t           acc_q;
	logic [CW-1:0]      chunk_q;
	logic [IDX_W-1:0]   count_q;

	logic [DIGIT_W-1:0]  divisor;
	logic                base2;
	logic [PAD_BITS-1:0] w_nxt;
	rdc_acc_t            acc_nxt;
	logic [DIGIT_W-1:0]  div_digit;
	logic                digit_done;
	logic                item_acc;
	logic                result_acc;
	logic                mem_wr_en;
	logic                mem_rd_en;
	logic [IDX_W-1:0]    mem_rd_addr;

	// radix decode
	assign divisor = radix_divisor(radix_select_q);
	assign base2   = (divisor == RADIX_TWO);

	// handshakes
	assign item_stall   = (state_q != ST_IDLE);
	assign item_acc     = item_valid & ~item_stall;
	assign result_valid = (state_q == ST_SHOW);
	assign result_acc   = result_valid & ~result_stall;
	assign last         = (count_q == '0);

	// digit finishes every cycle in base 2, else on the final chunk
	assign digit_done = base2 | (chunk_q == LAST_CHNK);
	assign mem_wr_en  = (state_q == ST_DIV) & digit_done;

	// read the top digit on load, the next one when a digit is taken
	assign mem_rd_en   = (state_q == ST_LOAD) | (result_acc & ~last);
	assign mem_rd_addr = (state_q == ST_LOAD) ? count_q : count_q - 1'b1;

	rdc_div_unit #(
		.VALUE_BITS (VALUE_BITS)
	) u_div (
		.divisor (divisor),
		.base2   (base2),
		.w       (w_q),
		.acc_in  (acc_q),
		.w_next  (w_nxt),
		.acc_out (acc_nxt),
		.digit   (div_digit)
	);

	rdc_digit_mem #(
		.VALUE_BITS (VALUE_BITS)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (count_q),
		.wr_data (div_digit),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (digit)
	);

	// radix register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_select_q <= SEL_BASE2;
		end else if (cfg_wr_en) begin
			radix_select_q <= cfg_wr_data;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			chunk_q <= '0;
			acc_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (item_acc) begin
						count_q <= '0;
						chunk_q <= '0;
						acc_q   <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (digit_done) begin
						chunk_q <= '0;
						acc_q   <= '0;
						if (!acc_nxt.nz || count_q == LAST_IDX) begin
							state_q <= ST_LOAD;
						end else begin
							count_q <= count_q + 1'b1;
						end
					end else begin
						chunk_q <= chunk_q + 1'b1;
						acc_q   <= acc_nxt;
					end
				end
				ST_LOAD: begin
					state_q <= ST_SHOW;
				end
				ST_SHOW: begin
					if (result_acc) begin
						if (last) begin
							state_q <= ST_IDLE;
						end else begin
							count_q <= count_q - 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// working quotient
	always_ff @(posedge clk) begin
		if (item_acc) begin
			w_q <= PAD_BITS'(value);
		end else if (state_q == ST_DIV) begin
			w_q <= w_nxt;
		end
	end

	// no new request is taken while digits are still going out
	a_no_accept_while_emit: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> item_stall)
		else $error("item accepted while digits pending");

	// the final digit ends the run
	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_stall && last) |=> !result_valid)
		else $error("digit shown after last");

	// every digit is below the selected radix
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (digit < divisor))
		else $error("digit out of range for radix");

	// digit index stays inside the store
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= LAST_IDX)
		else $error("digit index beyond store");

endmodule

### tb/radix_digit_converter_tb.sv
// self-checking testbench for the radix digit converter: directed table, then random requests
`timescale 1ns / 1ps

module radix_digit_converter_tb;
	import rdc_pkg::*;

	localparam int VW = VALUE_BITS_DEF;
	localparam logic [SEL_W-1:0] SEL_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE_CYCLES = 4;
	localparam int DRAIN_CYCLES = 100;
	localparam int NUM_PHASES = 7;
	localparam int PHASE_LEN = 37;
	localparam int NUM_ROWS = 22;

	// one emitted digit
	typedef struct packed {
		logic [DIGIT_W-1:0] digit;
		logic               last;
	} digit_rec_t;

	// one directed row: radix, value, and a typed single-digit answer where obvious
	typedef struct packed {
		logic [SEL_W-1:0]   sel;
		logic [VW-1:0]      val;
		logic               typed;
		logic [DIGIT_W-1:0] typed_digit;
	} conv_row_t;

	typedef enum logic [1:0] {STALL_NONE, STALL_SPARSE, STALL_RUNS} stall_mode_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_wr_en;
	logic [SEL_W-1:0]    cfg_wr_data;
	logic                item_valid;
	logic                item_stall;
	logic [VW-1:0]       value;
	logic                result_valid;
	logic                result_stall;
	logic [DIGIT_W-1:0]  digit;
	logic                last;

	digit_rec_t       digit_q [$];
	digit_rec_t       want_rec;
	logic [SEL_W-1:0] radix_sel;
	int               burst_left;
	int               fail_cnt;
	int               cycle_cnt;

	conv_row_t dir_rows [NUM_ROWS] = '{
		'{SEL_BASE2,  31'd0,          1'b1, 4'd0},
		'{SEL_BASE2,  31'd1,          1'b1, 4'd1},
		'{SEL_BASE2,  31'h7FFFFFFF,   1'b0, 4'd0},
		'{SEL_BASE2,  31'h40000000,   1'b0, 4'd0},
		'{SEL_BASE2,  31'h2AAAAAAA,   1'b0, 4'd0},
		'{SEL_BASE2,  31'h55555555,   1'b0, 4'd0},
		'{SEL_BASE5,  31'd0,          1'b1, 4'd0},
		'{SEL_BASE5,  31'd4,          1'b1, 4'd4},
		'{SEL_BASE5,  31'd5,          1'b0, 4'd0},
		'{SEL_BASE5,  31'h7FFFFFFF,   1'b0, 4'd0},
		'{SEL_BASE5,  31'd24,         1'b0, 4'd0},
		'{SEL_BASE12, 31'd0,          1'b1, 4'd0},
		'{SEL_BASE12, 31'd10,         1'b1, 4'd10},
		'{SEL_BASE12, 31'd11,         1'b1, 4'd11},
		'{SEL_BASE12, 31'd143,        1'b0, 4'd0},
		'{SEL_BASE12, 31'h7FFFFFFF,   1'b0, 4'd0},
		'{SEL_BASE12, 31'd144,        1'b0, 4'd0},
		'{SEL_UNUSED, 31'd0,          1'b1, 4'd0},
		'{SEL_UNUSED, 31'd1,          1'b1, 4'd1},
		'{SEL_UNUSED, 31'h7FFFFFFF,   1'b0, 4'd0},
		'{SEL_UNUSED, 31'd6,          1'b0, 4'd0},
		'{SEL_BASE2,  31'd2,          1'b0, 4'd0}
	};

	radix_digit_converter #(.VALUE_BITS(VW)) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.value        (value),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.digit        (digit),
		.last         (last)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// divide repeatedly, then queue the remainders most significant first
	function automatic void predict_digits(input logic [VW-1:0] v, input logic [SEL_W-1:0] sel);
		logic [VW-1:0]      quo;
		logic [DIGIT_W-1:0] base;
		logic [DIGIT_W-1:0] rems [VW];
		int                 n;
		case (sel)
			SEL_BASE5:  base = RADIX_FIVE;
			SEL_BASE12: base = RADIX_TWELVE;
			default:    base = RADIX_TWO;
		endcase
		quo = v;
		n = 0;
		do begin
			rems[n] = DIGIT_W'(quo % base);
			quo = quo / base;
			n++;
		end while (quo != 0 && n < VW);
		for (int k = n - 1; k >= 0; k--)
			digit_q.push_back('{rems[k], k == 0});
	endfunction

	// send one request, with a random gap when the current burst runs out
	task automatic convert_one(input logic [VW-1:0] v, input logic typed,
		input logic [DIGIT_W-1:0] typed_digit);
		int idle_len;
		if (burst_left == 0) begin
			idle_len = $urandom_range(1, 15);
			item_valid <= 1'b0;
			value <= VW'($urandom);
			repeat (idle_len) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) :
				$urandom_range(1, 10);
		end
		burst_left--;
		item_valid <= 1'b1;
		value <= v;
		do @(posedge clk); while (item_stall);
		if (typed)
			digit_q.push_back('{typed_digit, 1'b1});
		else
			predict_digits(v, radix_sel);
	endtask

	// change the radix once every pending digit is out
	task automatic write_radix(input logic [SEL_W-1:0] sel);
		item_valid <= 1'b0;
		while (digit_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= sel;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= SEL_W'($urandom);
		radix_sel = sel;
		burst_left = 0;
	endtask

	// receiver stall pattern, switching between no stalls, sparse stalls and long runs
	initial begin
		stall_mode_t mode;
		int          mode_left;
		int          run_left;
		result_stall <= 1'b0;
		mode = STALL_NONE;
		mode_left = 0;
		run_left = 0;
		forever begin
			@(posedge clk);
			if (mode_left == 0) begin
				mode = stall_mode_t'($urandom_range(0, 2));
				mode_left = $urandom_range(50, 300);
			end
			mode_left--;
			case (mode)
				STALL_NONE: begin
					result_stall <= 1'b0;
				end
				STALL_SPARSE: begin
					result_stall <= ($urandom_range(0, 3) == 0);
				end
				default: begin
					if (run_left == 0) begin
						run_left = $urandom_range(1, 12);
						result_stall <= ~result_stall;
					end
					run_left--;
				end
			endcase
		end
	end

	// compare each taken digit with the oldest pending one
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (digit_q.size() == 0) begin
				fail_cnt++;
				if (fail_cnt <= 10)
					$display("unexpected digit %0d last %0d, nothing pending", digit, last);
			end else begin
				want_rec = digit_q.pop_front();
				if (digit !== want_rec.digit || last !== want_rec.last) begin
					fail_cnt++;
					if (fail_cnt <= 10)
						$display("digit mismatch: expected %0d last %0d, got %0d last %0d",
							want_rec.digit, want_rec.last, digit, last);
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// stimulus
	initial begin
		logic [VW-1:0] v;
		logic [VW-1:0] ones;
		int            w;
		ones = '1;
		fail_cnt = 0;
		burst_left = 0;
		radix_sel = SEL_BASE2;
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= SEL_BASE2;
		item_valid <= 1'b0;
		value <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, first rows run on the reset radix
		for (int i = 0; i < NUM_ROWS; i++) begin
			if (dir_rows[i].sel != radix_sel)
				write_radix(dir_rows[i].sel);
			convert_one(dir_rows[i].val, dir_rows[i].typed, dir_rows[i].typed_digit);
		end

		// random phases, each selector once, then random selectors
		for (int p = 0; p < NUM_PHASES; p++) begin
			write_radix(p < 4 ? SEL_W'(p) : SEL_W'($urandom_range(0, 3)));
			for (int i = 0; i < PHASE_LEN; i++) begin
				w = $urandom_range(1, VW);
				case ($urandom_range(0, 15))
					0:       v = '0;
					1:       v = ones;
					2, 3:    v = ones >> (VW - w);
					default: v = VW'($urandom) & (ones >> (VW - w));
				endcase
				convert_one(v, 1'b0, '0);
			end
		end
		item_valid <= 1'b0;

		while (digit_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_cnt == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

### filelist.f
rtl/core/rdc_pkg.sv
rtl/core/rdc_div_unit.sv
rtl/core/rdc_digit_mem.sv
rtl/core/radix_digit_converter.sv
tb/radix_digit_converter_tb.sv
